// ----- rtl/core/dmx_frame_transmitter_top_defines.svh -----
// Assertion helpers for the DMX frame transmitter.
// Each macro samples on the rising edge of clk_i and is disabled during reset.
`ifndef DMX_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define DMX_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// Check a property that must hold at every clock edge.
`define DMXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DMXT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dmxt_pkg.sv -----
package dmxt_pkg;

  // Default frame length in slots.
  localparam int unsigned SlotsDefault = 512;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned LoadW     = 8;

  // Slot byte is taken from the sample starting at this bit.
  localparam int unsigned SampleShift = 2;

  localparam logic [ByteW-1:0] StartCode = 8'h00;

  // Event codes on the input channel.
  typedef enum logic [CmdW-1:0] {
    CmdReady = 2'd0,
    CmdTimer = 2'd1,
    CmdStore = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgMarkBeforeBreak = 2'd0,
    CfgBreak           = 2'd1,
    CfgMarkAfterBreak  = 2'd2
  } cfg_idx_e;

endpackage

// ----- rtl/core/dmxt_slot_buf.sv -----
module dmxt_slot_buf #(
  parameter int unsigned SLOTS = dmxt_pkg::SlotsDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    wr_en_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr_i,
  input  logic [dmxt_pkg::ByteW-1:0]              wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr_i,
  output logic [dmxt_pkg::ByteW-1:0]              rd_data_o
);
  import dmxt_pkg::*;

  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  logic [ByteW-1:0] mem [SLOTS];
  logic [ByteW-1:0] rd_q;
  logic             hit_q;
  // Writes fill the buffer in order from entry 0, so a count of written
  // entries tells which reads must return the reset value of zero.
  logic [CntW-1:0]  fill_q, fill_d;

  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (fill_q != CntW'(SLOTS))) begin
      fill_d = fill_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        hit_q <= CntW'(rd_addr_i) < fill_q;
      end
    end
  end

  assign rd_data_o = hit_q ? rd_q : '0;

endmodule

// ----- rtl/core/dmx_frame_transmitter_top.sv -----
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o   | cmd_i, sample_i
// result    | out_valid_o / out_ready_i | send_valid_o, send_byte_o,
//           |                           | timer_load_valid_o, timer_load_o,
//           |                           | line_forced_low_o
// config    | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One beat is accepted every cycle while the result side keeps up.
// A result passes through the read stage, which waits on the registered
// slot-buffer read, and then through the output register.
// The slot buffer is a single-port-write, single-port-read memory; entries
// not yet written read as zero through a fill count.
// A stall on the result side holds the read stage and then the input channel.
`include "dmx_frame_transmitter_top_defines.svh"

module dmx_frame_transmitter_top #(
  parameter int unsigned SLOTS = dmxt_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dmxt_pkg::CmdW-1:0]    cmd_i,
  input  logic [dmxt_pkg::SampleW-1:0] sample_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         send_valid_o,
  output logic [dmxt_pkg::ByteW-1:0]   send_byte_o,
  output logic                         timer_load_valid_o,
  output logic [dmxt_pkg::LoadW-1:0]   timer_load_o,
  output logic                         line_forced_low_o,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [dmxt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dmxt_pkg::ByteW-1:0]   cfg_data_i
);
  import dmxt_pkg::*;

  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    TxStart  = 2'd0,
    TxSlots  = 2'd1,
    TxSilent = 2'd2
  } tx_phase_e;

  typedef enum logic [1:0] {
    BrkIdle = 2'd0,
    BrkLow  = 2'd1,
    BrkMark = 2'd2
  } brk_phase_e;

  // Result waiting for the slot-buffer read data.
  typedef struct packed {
    logic             snd;
    logic             from_mem;
    logic             tld;
    logic [LoadW-1:0] tl;
    logic             low;
  } res_t;

  // Configuration registers.
  logic [LoadW-1:0] mbb_q, brk_q, mab_q;

  // Sequencer state.
  tx_phase_e        tx_phase_q, tx_phase_d;
  brk_phase_e       brk_phase_q, brk_phase_d;
  logic [CntW-1:0]  slot_cnt_q, slot_cnt_d;
  logic             tx_gate_q, tx_gate_d;
  logic             timer_gate_q, timer_gate_d;
  logic             line_low_q, line_low_d;
  logic [AddrW-1:0] store_idx_q, store_idx_d;

  // Read stage and output register.
  logic             s1_v_q, s1_v_d;
  res_t             s1_q, res;
  logic             res_v;
  logic             out_v_q;
  logic             snd_q, tld_q, low_q;
  logic [ByteW-1:0] byte_q;
  logic [LoadW-1:0] tl_q;

  logic             accept, s1_adv;
  logic             rd_en, wr_en;
  logic [ByteW-1:0] rd_data;

  // Advance the read stage when the output register is free or drains.
  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Event decode: next sequencer state and the result the beat causes.
  always_comb begin
    tx_phase_d   = tx_phase_q;
    brk_phase_d  = brk_phase_q;
    slot_cnt_d   = slot_cnt_q;
    tx_gate_d    = tx_gate_q;
    timer_gate_d = timer_gate_q;
    line_low_d   = line_low_q;
    store_idx_d  = store_idx_q;
    res          = '0;
    res_v        = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    if (accept) begin
      case (cmd_i)
        CmdReady: begin
          if (tx_gate_q) begin
            unique case (tx_phase_q)
              TxStart: begin
                tx_phase_d = TxSlots;
                slot_cnt_d = '0;
                res.snd    = 1'b1;
                res_v      = 1'b1;
              end
              TxSlots: begin
                if (slot_cnt_q < CntW'(SLOTS)) begin
                  // Fetch the slot byte; the registered read data joins the result when the read stage advances.
                  rd_en        = 1'b1;
                  slot_cnt_d   = slot_cnt_q + CntW'(1);
                  res.snd      = 1'b1;
                  res.from_mem = 1'b1;
                  res_v        = 1'b1;
                end else begin
                  slot_cnt_d = '0;
                  tx_phase_d = TxSilent;
                end
              end
              TxSilent: begin
                tx_phase_d   = TxStart;
                tx_gate_d    = 1'b0;
                timer_gate_d = 1'b1;
                res.tld      = 1'b1;
                res.tl       = mbb_q;
                res_v        = 1'b1;
              end
              default: begin
                tx_phase_d = TxStart;
              end
            endcase
          end
        end
        CmdTimer: begin
          if (timer_gate_q) begin
            unique case (brk_phase_q)
              BrkIdle: begin
                line_low_d  = 1'b1;
                brk_phase_d = BrkLow;
                res.tld     = 1'b1;
                res.tl      = brk_q;
                res_v       = 1'b1;
              end
              BrkLow: begin
                line_low_d  = 1'b0;
                brk_phase_d = BrkMark;
                res.tld     = 1'b1;
                res.tl      = mab_q;
                res_v       = 1'b1;
              end
              BrkMark: begin
                timer_gate_d = 1'b0;
                tx_gate_d    = 1'b1;
                brk_phase_d  = BrkIdle;
              end
              default: begin
                brk_phase_d = BrkIdle;
              end
            endcase
          end
        end
        CmdStore: begin
          wr_en = 1'b1;
          if (store_idx_q == AddrW'(SLOTS - 1)) begin
            store_idx_d = '0;
          end else begin
            store_idx_d = store_idx_q + AddrW'(1);
          end
        end
        default: begin
        end
      endcase
      res.low = line_low_d;
    end
  end

  // Read stage: hold while the output register is stalled.
  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = res_v;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
  end

  dmxt_slot_buf #(
    .SLOTS(SLOTS)
  ) u_slot_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (store_idx_q),
    .wr_data_i (sample_i[SampleShift +: ByteW]),
    .rd_en_i   (rd_en),
    .rd_addr_i (slot_cnt_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbb_q        <= '0;
      brk_q        <= '0;
      mab_q        <= '0;
      tx_phase_q   <= TxStart;
      brk_phase_q  <= BrkIdle;
      slot_cnt_q   <= '0;
      tx_gate_q    <= 1'b1;
      timer_gate_q <= 1'b0;
      line_low_q   <= 1'b0;
      store_idx_q  <= '0;
      s1_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMarkBeforeBreak: mbb_q <= cfg_data_i;
          CfgBreak:           brk_q <= cfg_data_i;
          CfgMarkAfterBreak:  mab_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      tx_phase_q   <= tx_phase_d;
      brk_phase_q  <= brk_phase_d;
      slot_cnt_q   <= slot_cnt_d;
      tx_gate_q    <= tx_gate_d;
      timer_gate_q <= timer_gate_d;
      line_low_q   <= line_low_d;
      store_idx_q  <= store_idx_d;
      s1_v_q       <= s1_v_d;
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (s1_adv) begin
      snd_q  <= s1_q.snd;
      byte_q <= !s1_q.snd ? '0 : (s1_q.from_mem ? rd_data : StartCode);
      tld_q  <= s1_q.tld;
      tl_q   <= s1_q.tl;
      low_q  <= s1_q.low;
    end
  end

  assign out_valid_o        = out_v_q;
  assign send_valid_o       = snd_q;
  assign send_byte_o        = byte_q;
  assign timer_load_valid_o = tld_q;
  assign timer_load_o       = tl_q;
  assign line_forced_low_o  = low_q;

  // Exactly one of the two gates is open at any time.
  `DMXT_ASSERT(a_gates_exclusive, tx_gate_q != timer_gate_q, "gates not exclusive")
  // The line is only forced low inside the break sequence.
  `DMXT_ASSERT(a_low_in_break, !line_low_q || timer_gate_q, "line low outside break")
  // The slot counter never runs past the frame length.
  `DMXT_ASSERT(a_slot_bound, slot_cnt_q <= CntW'(SLOTS), "slot counter overflow")
  // A stalled read stage keeps its result.
  `DMXT_ASSERT_NEXT(a_s1_hold, s1_v_q && !s1_adv, s1_v_q, "read stage lost a result")

endmodule
